FILE: rtl/core/buck_feedforward_duty_slew_defines.svh
// assertion macros shared by the rtl files
`ifndef BUCK_FEEDFORWARD_DUTY_SLEW_DEFINES_SVH
`define BUCK_FEEDFORWARD_DUTY_SLEW_DEFINES_SVH

`ifndef SYNTH

`define BFDS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

`define BFDS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next cycle check failed");

`else

`define BFDS_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define BFDS_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/core/bfds_pkg.sv
package bfds_pkg;

    localparam int SetWidth  = 16;
    localparam int VinWidth  = 16;
    localparam int DutyWidth = 8;
    localparam int TgtWidth  = 17;
    localparam int NumWidth  = DutyWidth + VinWidth;

    localparam logic [3:0] DropScale = 4'd10;

    localparam logic [1:0] ModeFixed = 2'd0;
    localparam logic [1:0] ModeOff   = 2'd1;
    localparam logic [1:0] ModeAuto  = 2'd2;

    localparam logic RegMode   = 1'b0;
    localparam logic RegAmount = 1'b1;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] amount;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

FILE: rtl/core/bfds_if.sv
interface bfds_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] set_voltage;
    logic [15:0] input_voltage;

    modport source (output valid, output set_voltage, output input_voltage, input ready);
    modport sink (input valid, input set_voltage, input input_voltage, output ready);
endinterface

interface bfds_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] duty;

    modport source (output valid, output duty, input ready);
    modport sink (input valid, input duty, output ready);
endinterface

FILE: rtl/core/bfds_regs.sv
module bfds_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output bfds_pkg::cfg_t     cfg
);

    logic [1:0] mode_reg;
    logic [7:0] amount_reg;
    logic       wr_en;

    // low address bits select a byte within the word and are ignored
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= bfds_pkg::ModeOff;
            amount_reg <= 8'd0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                bfds_pkg::RegMode:   mode_reg   <= pwdata[1:0];
                bfds_pkg::RegAmount: amount_reg <= pwdata[7:0];
                default:             mode_reg   <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            bfds_pkg::RegMode:   prdata = {30'd0, mode_reg};
            bfds_pkg::RegAmount: prdata = {24'd0, amount_reg};
            default:             prdata = 32'd0;
        endcase
    end

    assign cfg.mode   = mode_reg;
    assign cfg.amount = amount_reg;

endmodule

FILE: rtl/core/bfds_div.sv
`include "buck_feedforward_duty_slew_defines.svh"

module bfds_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [bfds_pkg::NumWidth-1:0]      num,
    input  logic [bfds_pkg::VinWidth-1:0]      den,
    output logic [bfds_pkg::DutyWidth-1:0]     quo,
    output bfds_pkg::div_status_t              sts
);

    localparam int QW = bfds_pkg::DutyWidth;
    localparam int DW = bfds_pkg::VinWidth;
    localparam logic [2:0] LastStep = 3'(QW - 1);

    logic [DW-1:0] rem_reg;
    logic [QW-1:0] low_reg;
    logic [QW-1:0] quo_reg;
    logic [2:0]    cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    // one restoring step per cycle; caller guarantees quotient fits QW bits
    assign trial = {rem_reg, low_reg[QW-1]};
    assign diff  = trial - {1'b0, den};
    assign ge    = trial >= {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == LastStep)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[bfds_pkg::NumWidth-1:QW];
            low_reg <= num[QW-1:0];
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            low_reg <= {low_reg[QW-2:0], 1'b0};
            quo_reg <= {quo_reg[QW-2:0], ge};
        end
    end

    assign quo      = quo_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

    `BFDS_ASSERT_NXT(a_start_busy, clk, rst_n, start, busy_reg)
    `BFDS_ASSERT_IMP(a_done_idle, clk, rst_n, done_reg, !busy_reg)
    `BFDS_ASSERT_NXT(a_busy_holds, clk, rst_n, busy_reg && cnt_reg != LastStep && !start, busy_reg)

endmodule

FILE: rtl/core/buck_feedforward_duty_slew.sv
// Feed-forward buck duty with slew limit. Each item carries a setpoint and an input
// voltage reading; the block forms target = setpoint + 10 * drop_amount and, in fixed
// headroom mode with the input above target, a wanted duty of PWM_MAX * target / input
// (truncated), else PWM_MAX. The emitted duty moves at most one count per item toward
// the wanted duty. An item that needs the division passes through the target, multiply,
// divide, slew and output states, the 8-step restoring divider forming the quotient one
// bit per cycle in the divide state; an item that needs no division skips that state.
// The block is not ready again until the result has been taken.
`include "buck_feedforward_duty_slew_defines.svh"

module buck_feedforward_duty_slew #(
    parameter int PWM_MAX = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    bfds_in_if.sink     in_ch,
    bfds_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [7:0] PwmMax = 8'(PWM_MAX);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_TGT  = 6'b000010,
        S_MUL  = 6'b000100,
        S_DIV  = 6'b001000,
        S_SLEW = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    bfds_pkg::cfg_t        cfg;
    bfds_pkg::div_status_t div_sts;

    logic [bfds_pkg::SetWidth-1:0]  setv_reg;
    logic [bfds_pkg::VinWidth-1:0]  vin_reg;
    logic [bfds_pkg::TgtWidth-1:0]  target_reg;
    logic [bfds_pkg::NumWidth-1:0]  num_reg;
    logic [7:0]                     wanted_reg;
    logic [7:0]                     duty_reg;
    logic [7:0]                     quo;
    logic                           start_reg;
    logic                           do_div;
    logic                           in_acc;

    bfds_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bfds_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .num   (num_reg),
        .den   (vin_reg),
        .quo   (quo),
        .sts   (div_sts)
    );

    assign in_acc = in_ch.valid && in_ch.ready;

    // unused mode code three falls back to fixed headroom
    assign do_div = (cfg.mode != bfds_pkg::ModeOff) && (cfg.mode != bfds_pkg::ModeAuto)
                    && ({1'b0, vin_reg} > target_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_ch.valid) state_next = S_TGT;
            S_TGT:  state_next = S_MUL;
            S_MUL:  state_next = do_div ? S_DIV : S_SLEW;
            S_DIV:  if (div_sts.done) state_next = S_SLEW;
            S_SLEW: state_next = S_OUT;
            S_OUT:  if (out_ch.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            duty_reg  <= 8'd0;
            start_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= (state_reg == S_MUL) && do_div;
            if (state_reg == S_SLEW)
            begin
                if (wanted_reg > duty_reg)
                    duty_reg <= duty_reg + 8'd1;
                else if (wanted_reg < duty_reg)
                    duty_reg <= duty_reg - 8'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            setv_reg <= in_ch.set_voltage;
            vin_reg  <= in_ch.input_voltage;
        end
        if (state_reg == S_TGT)
            target_reg <= {1'b0, setv_reg}
                          + 17'(cfg.amount) * 17'(bfds_pkg::DropScale);
        if (state_reg == S_MUL)
        begin
            // when dividing, target is below the input here, so it fits the input width
            num_reg    <= 24'(PwmMax) * 24'(target_reg[bfds_pkg::VinWidth-1:0]);
            wanted_reg <= PwmMax;
        end
        if ((state_reg == S_DIV) && div_sts.done)
            wanted_reg <= quo;
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.duty  = duty_reg;

    `BFDS_ASSERT_IMP(a_ready_excl, clk, rst_n, in_ch.ready, !out_ch.valid)
    `BFDS_ASSERT_IMP(a_done_in_div, clk, rst_n, div_sts.done, state_reg == S_DIV)
    `BFDS_ASSERT_IMP(a_busy_in_div, clk, rst_n, div_sts.busy, state_reg == S_DIV)
    `BFDS_ASSERT_IMP(a_wanted_range, clk, rst_n, state_reg == S_SLEW, wanted_reg <= PwmMax)
    `BFDS_ASSERT_NXT(a_slew_step, clk, rst_n, state_reg == S_SLEW,
        (8'(duty_reg - $past(duty_reg)) == 8'd0) || (8'(duty_reg - $past(duty_reg)) == 8'd1)
        || (8'(duty_reg - $past(duty_reg)) == 8'd255))

endmodule
